FILE: src/nse_pkg.sv
package nse_pkg;

  // fixed point layout
  localparam int FRAC_BITS = 16;
  localparam int PAR_W     = FRAC_BITS + 1;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int CNT_W     = 5;
  localparam int IDX_W     = 4;
  localparam int COORD_W   = 32;

  // basis and weight path widths
  localparam int NB_W   = FRAC_BITS + 1;
  localparam int BB_W   = 2 * NB_W;
  localparam int WB_W   = COORD_W + NB_W + 1;
  localparam int E_W    = COORD_W + 1;
  localparam int PROD_W = E_W + COORD_W;

  // accumulators: nine terms
  localparam int ACC_W = PROD_W + 3;
  localparam int DEN_W = E_W + 3;

  // divider widths
  localparam int QB  = COORD_W + 1;
  localparam int N_W = ACC_W + 1;
  localparam int D_W = DEN_W + 1;

  // item kinds and register indexes
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_EVAL   = 1'b1;
  localparam logic REG_COUNT_U = 1'b0;
  localparam logic REG_COUNT_V = 1'b1;

  typedef logic [NB_W-1:0] basis_t;

  typedef struct packed {
    logic          done;
    logic          ovf;
    logic [QB-1:0] q;
  } div_result_t;

endpackage

FILE: src/nurbs_surface_evaluator_core.sv
// channel   signals                                   direction
// input     in_valid/in_ready, kind .. v_param        in
// output    out_valid/out_ready, out_x .. status      out
// config    cfg_write, cfg_index, cfg_data            in, no handshake
//
// a write beat leaves the core in idle, ready for the next beat; an evaluate beat
// holds the input through the basis pipeline, nine net reads through the single
// memory read port and multiply pipeline, the bit-serial dividers (a load, then a
// 33-bit quotient), the output register load and the return to idle. a zero
// weight sum skips the dividers. one item is worked at a time; a finished result
// waits in the output register while the next item is taken, and a stalled
// output holds the sequencer in its output state. reset clears control state
// only; the net memory is undefined until written and needs no clearing pass.
module nurbs_surface_evaluator_core #(
  parameter int MAX_NET_SIDE = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               kind,
  input  logic [nse_pkg::IDX_W-1:0]          row_index,
  input  logic [nse_pkg::IDX_W-1:0]          col_index,
  input  logic signed [nse_pkg::COORD_W-1:0] point_x_in,
  input  logic signed [nse_pkg::COORD_W-1:0] point_y_in,
  input  logic signed [nse_pkg::COORD_W-1:0] point_z_in,
  input  logic signed [nse_pkg::COORD_W-1:0] weight_in,
  input  logic [nse_pkg::PAR_W-1:0]          u_param,
  input  logic [nse_pkg::PAR_W-1:0]          v_param,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [nse_pkg::COORD_W-1:0] out_x,
  output logic signed [nse_pkg::COORD_W-1:0] out_y,
  output logic signed [nse_pkg::COORD_W-1:0] out_z,
  output logic                               status,
  input  logic                               cfg_write,
  input  logic                               cfg_index,
  input  logic [nse_pkg::CNT_W-1:0]          cfg_data
);
  import nse_pkg::*;

  localparam int SIDE_W = $clog2(MAX_NET_SIDE);
  localparam int AW     = 2 * SIDE_W;
  localparam int DEPTH  = 1 << AW;
  localparam int WORD_W = 4 * COORD_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BASIS = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [1:0] BASIS_LAST = 2'd2;
  localparam logic [3:0] TAPS       = 4'd9;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [CNT_W-1:0] count_u;
  logic [CNT_W-1:0] count_v;
  logic [PAR_W-1:0] u_reg;
  logic [PAR_W-1:0] v_reg;
  logic [1:0]       wait_cnt;

  logic accept;
  logic wr_ok;

  // ---- configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count_u <= CNT_W'(3);
      count_v <= CNT_W'(3);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COUNT_U: count_u <= cfg_data;
        REG_COUNT_V: count_v <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign wr_ok    = (32'(row_index) < MAX_NET_SIDE) && (32'(col_index) < MAX_NET_SIDE);

  always_ff @(posedge clk) begin
    if (accept && kind == KIND_EVAL) begin
      u_reg <= u_param;
      v_reg <= v_param;
    end
  end

  // ---- basis units
  logic [SIDE_W-1:0] ku;
  logic [SIDE_W-1:0] kv;
  basis_t nu0, nu1, nu2, nv0, nv1, nv2;

  nse_basis #(.MAX_NET_SIDE(MAX_NET_SIDE)) u_basis_u (
    .clk(clk), .par(u_reg), .cnt(count_u), .k(ku), .nb0(nu0), .nb1(nu1), .nb2(nu2)
  );

  nse_basis #(.MAX_NET_SIDE(MAX_NET_SIDE)) u_basis_v (
    .clk(clk), .par(v_reg), .cnt(count_v), .k(kv), .nb0(nv0), .nb1(nv1), .nb2(nv2)
  );

  // ---- net memory: {w, x, y, z} per entry
  logic [WORD_W-1:0] net_mem [0:DEPTH-1];
  logic [WORD_W-1:0] mem_q;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;

  assign mem_we  = accept && kind == KIND_WRITE && wr_ok;
  assign wr_addr = {SIDE_W'(row_index), SIDE_W'(col_index)};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      net_mem[wr_addr] <= {weight_in, point_x_in, point_y_in, point_z_in};
    end
    mem_q <= net_mem[rd_addr];
  end

  // ---- tap sequencing
  logic [1:0] ta;
  logic [1:0] tb;
  logic [3:0] issue_cnt;
  logic       issue;
  basis_t     nu_sel;
  basis_t     nv_sel;
  logic [BB_W-1:0] bb;

  assign issue   = (state == ST_MAC) && (issue_cnt < TAPS);
  assign rd_addr = {SIDE_W'((SIDE_W + 1)'(ku) + (SIDE_W + 1)'(ta)),
                    SIDE_W'((SIDE_W + 1)'(kv) + (SIDE_W + 1)'(tb))};

  always_comb begin
    case (ta)
      2'd0:    nu_sel = nu0;
      2'd1:    nu_sel = nu1;
      default: nu_sel = nu2;
    endcase
    case (tb)
      2'd0:    nv_sel = nv0;
      2'd1:    nv_sel = nv1;
      default: nv_sel = nv2;
    endcase
    bb = BB_W'(nu_sel) * BB_W'(nv_sel);
  end

  // ---- multiply pipeline
  logic                      v1, v2, v3;
  basis_t                    b1;
  logic signed [WB_W-1:0]    wb;
  logic signed [E_W-1:0]     e2, e3;
  logic signed [COORD_W-1:0] x2, y2, z2;
  logic signed [PROD_W-1:0]  px, py, pz;
  logic signed [ACC_W-1:0]   acc_x, acc_y, acc_z;
  logic signed [DEN_W-1:0]   acc_d;
  logic                      clear_acc;

  assign clear_acc = accept && kind == KIND_EVAL;
  assign wb = $signed(mem_q[WORD_W-1 -: COORD_W]) * $signed({1'b0, b1});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    b1 <= NB_W'((bb + BB_W'(ONE / 2)) >> FRAC_BITS);
    e2 <= E_W'((wb + WB_W'(ONE / 2)) >>> FRAC_BITS);
    x2 <= mem_q[3*COORD_W-1 -: COORD_W];
    y2 <= mem_q[2*COORD_W-1 -: COORD_W];
    z2 <= mem_q[COORD_W-1:0];
    e3 <= e2;
    px <= e2 * x2;
    py <= e2 * y2;
    pz <= e2 * z2;
  end

  // weighted sums
  always_ff @(posedge clk) begin
    if (clear_acc) begin
      acc_x <= '0;
      acc_y <= '0;
      acc_z <= '0;
      acc_d <= '0;
    end else if (v3) begin
      acc_x <= acc_x + ACC_W'(px);
      acc_y <= acc_y + ACC_W'(py);
      acc_z <= acc_z + ACC_W'(pz);
      acc_d <= acc_d + DEN_W'(e3);
    end
  end

  // ---- division
  logic mac_end;
  logic div_start;
  logic den_zero;
  logic [DEN_W-1:0] abs_d;
  logic [ACC_W-1:0] abs_x, abs_y, abs_z;
  logic neg_x, neg_y, neg_z;
  div_result_t dres_x, dres_y, dres_z;

  assign mac_end   = (state == ST_MAC) && (issue_cnt == TAPS) && !v1 && !v2 && !v3;
  assign den_zero  = (acc_d == '0);
  assign div_start = mac_end && !den_zero;
  assign abs_d = acc_d[DEN_W-1] ? DEN_W'(-acc_d) : DEN_W'(acc_d);
  assign abs_x = acc_x[ACC_W-1] ? ACC_W'(-acc_x) : ACC_W'(acc_x);
  assign abs_y = acc_y[ACC_W-1] ? ACC_W'(-acc_y) : ACC_W'(acc_y);
  assign abs_z = acc_z[ACC_W-1] ? ACC_W'(-acc_z) : ACC_W'(acc_z);

  always_ff @(posedge clk) begin
    if (div_start) begin
      neg_x <= acc_x[ACC_W-1] ^ acc_d[DEN_W-1];
      neg_y <= acc_y[ACC_W-1] ^ acc_d[DEN_W-1];
      neg_z <= acc_z[ACC_W-1] ^ acc_d[DEN_W-1];
    end
  end

  nse_div u_div_x (.clk(clk), .rst(rst), .start(div_start), .an(abs_x), .ad(abs_d),
                   .res(dres_x));
  nse_div u_div_y (.clk(clk), .rst(rst), .start(div_start), .an(abs_y), .ad(abs_d),
                   .res(dres_y));
  nse_div u_div_z (.clk(clk), .rst(rst), .start(div_start), .an(abs_z), .ad(abs_d),
                   .res(dres_z));

  function automatic logic [COORD_W-1:0] sat_q(input div_result_t r, input logic neg);
    logic [QB-1:0] lim;
    lim = QB'(1) << (COORD_W - 1);
    if (neg) begin
      sat_q = (r.ovf || r.q > lim) ? lim[COORD_W-1:0] : COORD_W'(-r.q[COORD_W-1:0]);
    end else begin
      sat_q = (r.ovf || r.q >= lim) ? COORD_W'(lim - QB'(1)) : r.q[COORD_W-1:0];
    end
  endfunction

  // ---- result holding
  logic [COORD_W-1:0] res_x, res_y, res_z;
  logic               res_st;
  logic               load_out;

  always_ff @(posedge clk) begin
    if (mac_end && den_zero) begin
      res_x  <= '0;
      res_y  <= '0;
      res_z  <= '0;
      res_st <= 1'b1;
    end else if (state == ST_DIV && dres_x.done) begin
      res_x  <= sat_q(dres_x, neg_x);
      res_y  <= sat_q(dres_y, neg_y);
      res_z  <= sat_q(dres_z, neg_z);
      res_st <= 1'b0;
    end
  end

  assign load_out = (state == ST_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x  <= res_x;
      out_y  <= res_y;
      out_z  <= res_z;
      status <= res_st;
    end
  end

  // ---- sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept && kind == KIND_EVAL) state_next = ST_BASIS;
      ST_BASIS: if (wait_cnt == BASIS_LAST) state_next = ST_MAC;
      ST_MAC:   if (mac_end) state_next = den_zero ? ST_OUT : ST_DIV;
      ST_DIV:   if (dres_x.done) state_next = ST_OUT;
      ST_OUT:   if (load_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wait_cnt  <= '0;
      issue_cnt <= '0;
      ta        <= '0;
      tb        <= '0;
    end else begin
      state <= state_next;
      if (state == ST_BASIS) begin
        wait_cnt <= wait_cnt + 2'd1;
      end else begin
        wait_cnt <= '0;
      end
      if (state == ST_BASIS) begin
        issue_cnt <= '0;
        ta        <= '0;
        tb        <= '0;
      end else if (issue) begin
        issue_cnt <= issue_cnt + 4'd1;
        if (tb == 2'd2) begin
          tb <= '0;
          ta <= ta + 2'd1;
        end else begin
          tb <= tb + 2'd1;
        end
      end
    end
  end

  // ---- checks
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_WRITE && !out_valid) |=> !out_valid)
    else $error("write beat produced a result");

  a_zero_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (out_x == '0 && out_y == '0 && out_z == '0))
    else $error("error status with nonzero point");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    dres_x.done |-> (dres_y.done && dres_z.done))
    else $error("dividers out of step");

  a_tap_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC) |-> (issue_cnt <= TAPS))
    else $error("too many net reads");

endmodule

FILE: src/nse_basis.sv
module nse_basis #(
  parameter int MAX_NET_SIDE = 16
) (
  input  logic                            clk,
  input  logic [nse_pkg::PAR_W-1:0]       par,
  input  logic [nse_pkg::CNT_W-1:0]       cnt,
  output logic [$clog2(MAX_NET_SIDE)-1:0] k,
  output nse_pkg::basis_t                 nb0,
  output nse_pkg::basis_t                 nb1,
  output nse_pkg::basis_t                 nb2
);
  import nse_pkg::*;

  localparam int SIDE_W = $clog2(MAX_NET_SIDE);
  localparam int N_BITS = $clog2(MAX_NET_SIDE + 1);
  localparam int T_W    = PAR_W + N_BITS;
  localparam int GG_W   = 2 * PAR_W;

  logic [PAR_W-1:0]  p;
  logic [N_BITS-1:0] n;
  logic [N_BITS-1:0] spans;
  logic [T_W-1:0]    t;
  logic [N_BITS-1:0] kr;
  logic [N_BITS-1:0] kc;
  logic [T_W-1:0]    fw;
  logic [PAR_W-1:0]  f;
  logic [PAR_W-1:0]  g;
  logic              dl;
  logic              dr;

  logic [SIDE_W-1:0] k1;
  logic [PAR_W-1:0]  f1;
  logic [PAR_W-1:0]  g1;
  logic              dl1;
  logic              dr1;

  logic [GG_W-1:0]   gg;
  logic [GG_W-1:0]   ff;
  logic [SIDE_W-1:0] k2;
  basis_t            n0;
  basis_t            n2;
  logic signed [NB_W+1:0] mid;

  // span and local position
  always_comb begin
    p = (par > PAR_W'(ONE)) ? PAR_W'(ONE) : par;
    if (cnt < CNT_W'(3)) begin
      n = N_BITS'(3);
    end else if (32'(cnt) > MAX_NET_SIDE) begin
      n = N_BITS'(MAX_NET_SIDE);
    end else begin
      n = N_BITS'(cnt);
    end
    spans = n - N_BITS'(2);
    t     = T_W'(p) * T_W'(spans);
    kr    = N_BITS'(t >> FRAC_BITS);
    kc    = (kr >= spans) ? spans - N_BITS'(1) : kr;
    fw    = t - (T_W'(kc) << FRAC_BITS);
    f     = PAR_W'(fw);
    g     = PAR_W'(ONE) - f;
    dl    = (kc != '0);
    dr    = ({1'b0, kc} + (N_BITS+1)'(2)) <= {1'b0, spans};
  end

  always_ff @(posedge clk) begin
    k1  <= SIDE_W'(kc);
    f1  <= f;
    g1  <= g;
    dl1 <= dl;
    dr1 <= dr;
  end

  // outer basis values, rounded half up
  always_comb begin
    gg = GG_W'(g1) * GG_W'(g1);
    ff = GG_W'(f1) * GG_W'(f1);
  end

  always_ff @(posedge clk) begin
    k2 <= k1;
    n0 <= dl1 ? NB_W'((gg + GG_W'(ONE)) >> (FRAC_BITS + 1))
              : NB_W'((gg + GG_W'(ONE / 2)) >> FRAC_BITS);
    n2 <= dr1 ? NB_W'((ff + GG_W'(ONE)) >> (FRAC_BITS + 1))
              : NB_W'((ff + GG_W'(ONE / 2)) >> FRAC_BITS);
  end

  // middle basis value, clamped at zero
  assign mid = (NB_W+2)'(ONE) - $signed({2'b00, n0}) - $signed({2'b00, n2});

  always_ff @(posedge clk) begin
    k   <= k2;
    nb0 <= n0;
    nb2 <= n2;
    nb1 <= (mid < 0) ? '0 : NB_W'(mid);
  end

endmodule

FILE: src/nse_div.sv
module nse_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [nse_pkg::ACC_W-1:0]   an,
  input  logic [nse_pkg::DEN_W-1:0]   ad,
  output nse_pkg::div_result_t        res
);
  import nse_pkg::*;

  localparam int CW = $clog2(QB + 1);

  logic [N_W-1:0] num;
  logic [D_W-1:0] den;
  logic [D_W-1:0] d;
  logic [D_W-1:0] rem;
  logic [D_W:0]   r2;
  logic [QB-1:0]  nlow;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic           done_r;
  logic           ovf_r;
  logic [QB-1:0]  quo;

  // rounded quotient: (2|n| + |d|) / (2|d|)
  assign num = {an, 1'b0} + N_W'(ad);
  assign den = {ad, 1'b0};
  assign r2  = {rem, nlow[QB-1]};

  assign res = '{done: done_r, ovf: ovf_r, q: quo};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      cnt    <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QB);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      d     <= den;
      rem   <= D_W'(num[N_W-1:QB]);
      nlow  <= num[QB-1:0];
      ovf_r <= (D_W + 1)'(num[N_W-1:QB]) >= (D_W + 1)'(den);
      quo   <= '0;
    end else if (busy) begin
      nlow <= nlow << 1;
      if (r2 >= {1'b0, d}) begin
        rem <= D_W'(r2 - {1'b0, d});
        quo <= {quo[QB-2:0], 1'b1};
      end else begin
        rem <= D_W'(r2);
        quo <= {quo[QB-2:0], 1'b0};
      end
    end
  end

endmodule
